@@ sv/gated_pulse_tachometer_assert.svh @@
// Assertion macros for the gated pulse tachometer.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef GATED_PULSE_TACHOMETER_ASSERT_SVH
`define GATED_PULSE_TACHOMETER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TACH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tachometer check failed");

// Next-cycle implication, checked outside reset.
`define TACH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tachometer check failed");

`endif

@@ sv/tach_pkg.sv @@
// Shared types, constants and helper functions for the gated pulse tachometer.
// No dependencies.
package tach_pkg;

  localparam int GateW   = 24;
  localparam int MaxCntW = 16;
  localparam int ScaleW  = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 24;
  localparam int RpmW    = 14;
  localparam int BcdW    = 16;
  localparam int DigitW  = 6;
  localparam int DdW     = BcdW + RpmW;
  localparam int DdHalf  = RpmW / 2;

  localparam int QueueDepth = 4;

  localparam logic [GateW-1:0]   GateReset  = 24'd1000000;
  localparam logic [MaxCntW-1:0] MaxCntReset = 16'd166;
  localparam logic [ScaleW-1:0]  ScaleReset = 8'd60;
  localparam logic [RpmW-1:0]    RpmLimit   = 14'd9999;
  localparam logic [DigitW-1:0]  AsciiZero  = 6'h30;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGateTicks = 2'd0,
    CfgMaxCount  = 2'd1,
    CfgScale     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } tach_ctl_t;

  // One shift-add-3 step of binary to BCD conversion; acc is {bcd, binary}.
  function automatic logic [DdW-1:0] dd_step(input logic [DdW-1:0] acc);
    logic [DdW-1:0] a;
    a = acc;
    for (int k = 0; k < BcdW / 4; k++) begin
      if (a[RpmW + 4*k +: 4] >= 4'd5) begin
        a[RpmW + 4*k +: 4] = a[RpmW + 4*k +: 4] + 4'd3;
      end
    end
    return {a[DdW-2:0], 1'b0};
  endfunction

  function automatic logic [DigitW-1:0] to_ascii(input logic [3:0] d);
    return AsciiZero + {2'b00, d};
  endfunction

endpackage

@@ sv/tach_front.sv @@
// Front end: gate window sequencer and falling-edge pulse counter.
// Depends on tach_pkg; emits one classified word per accepted tick.
module tach_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            start_req_i,
  input  logic                            pulse_i,
  input  logic [tach_pkg::GateW-1:0]      gate_ticks_i,
  output tach_pkg::tach_ctl_t             ctl_o,
  output logic [COUNT_WIDTH-1:0]          count_o
);

  logic                       open_q, open_d;
  logic [tach_pkg::GateW-1:0] ticks_q, ticks_d;
  logic [COUNT_WIDTH-1:0]     count_q, count_d;
  logic                       last_q;
  logic                       done;

  always_comb begin
    open_d  = open_q;
    ticks_d = ticks_q;
    count_d = count_q;
    done    = 1'b0;
    if (!open_q) begin
      if (start_req_i) begin
        open_d  = 1'b1;
        count_d = '0;
        ticks_d = (gate_ticks_i == '0) ? tach_pkg::GateW'(1) : gate_ticks_i;
      end
    end else begin
      if (last_q && !pulse_i && (count_q != '1)) begin
        count_d = count_q + COUNT_WIDTH'(1);
      end
      ticks_d = ticks_q - tach_pkg::GateW'(1);
      if (ticks_q == tach_pkg::GateW'(1)) begin
        open_d = 1'b0;
        done   = 1'b1;
      end
    end
  end

  assign ctl_o.busy = open_d;
  assign ctl_o.done = done;
  assign count_o    = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      ticks_q <= '0;
      count_q <= '0;
      last_q  <= 1'b0;
    end else if (accept_i) begin
      open_q  <= open_d;
      ticks_q <= ticks_d;
      count_q <= count_d;
      last_q  <= pulse_i;
    end
  end

endmodule

@@ sv/tach_queue.sv @@
// Short first-word-fall-through queue between front and back end.
// Depends on nothing but its parameters.
module tach_queue #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ sv/tach_back.sv @@
// Back end: range check, rpm scaling with saturation, held result and
// binary to ASCII digit conversion. Depends on tach_pkg.
module tach_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_pop_o,
  input  tach_pkg::tach_ctl_t             ctl_i,
  input  logic [COUNT_WIDTH-1:0]          count_i,
  input  logic [tach_pkg::MaxCntW-1:0]    max_count_i,
  input  logic [tach_pkg::ScaleW-1:0]     scale_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic                            out_of_range_o,
  output logic [tach_pkg::RpmW-1:0]       rpm_o,
  output logic [tach_pkg::DigitW-1:0]     digit_thousands_o,
  output logic [tach_pkg::DigitW-1:0]     digit_hundreds_o,
  output logic [tach_pkg::DigitW-1:0]     digit_tens_o,
  output logic [tach_pkg::DigitW-1:0]     digit_ones_o
);

  localparam int ProdW = COUNT_WIDTH + tach_pkg::ScaleW;
  localparam int CmpW  = (COUNT_WIDTH > tach_pkg::MaxCntW) ? COUNT_WIDTH : tach_pkg::MaxCntW;

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  tach_pkg::tach_ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic [ProdW-1:0]    prod1_q;
  logic                oor1_q, oor2_q, oor3_q, oor4_q;
  logic [tach_pkg::RpmW-1:0] rpm2_q, rpm3_q, rpm4_q;
  logic [tach_pkg::DdW-1:0]  acc3_q;
  logic [tach_pkg::DigitW-1:0] d_th_q, d_hu_q, d_te_q, d_on_q;

  logic [tach_pkg::RpmW-1:0] held_rpm_q, held_rpm_d;
  logic                      held_oor_q, held_oor_d;
  logic [tach_pkg::RpmW-1:0] new_rpm, rpm2_d;
  logic                      oor2_d;
  logic [tach_pkg::DdW-1:0]  acc3_d, acc4_d;

  assign r4 = !v4_q || !out_stall_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign q_pop_o = q_valid_i && r1;

  always_comb begin
    if (oor1_q) begin
      new_rpm = '0;
    end else if (prod1_q > ProdW'(tach_pkg::RpmLimit)) begin
      new_rpm = tach_pkg::RpmLimit;
    end else begin
      new_rpm = prod1_q[tach_pkg::RpmW-1:0];
    end
    held_rpm_d = held_rpm_q;
    held_oor_d = held_oor_q;
    if (v1_q && ctl1_q.done) begin
      held_rpm_d = new_rpm;
      held_oor_d = oor1_q;
    end
    rpm2_d = held_rpm_d;
    oor2_d = held_oor_d;
  end

  always_comb begin
    acc3_d = {{tach_pkg::BcdW{1'b0}}, rpm2_q};
    for (int i = 0; i < tach_pkg::DdHalf; i++) begin
      acc3_d = tach_pkg::dd_step(acc3_d);
    end
    acc4_d = acc3_q;
    for (int i = tach_pkg::DdHalf; i < tach_pkg::RpmW; i++) begin
      acc4_d = tach_pkg::dd_step(acc4_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      held_rpm_q <= '0;
      held_oor_q <= 1'b0;
    end else begin
      if (r1) v1_q <= q_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r2 && v1_q) begin
        held_rpm_q <= held_rpm_d;
        held_oor_q <= held_oor_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ctl1_q  <= ctl_i;
      prod1_q <= ProdW'(count_i) * ProdW'(scale_i);
      oor1_q  <= CmpW'(count_i) > CmpW'(max_count_i);
    end
    if (r2 && v1_q) begin
      ctl2_q <= ctl1_q;
      rpm2_q <= rpm2_d;
      oor2_q <= oor2_d;
    end
    if (r3 && v2_q) begin
      ctl3_q <= ctl2_q;
      rpm3_q <= rpm2_q;
      oor3_q <= oor2_q;
      acc3_q <= acc3_d;
    end
    if (r4 && v3_q) begin
      ctl4_q <= ctl3_q;
      rpm4_q <= rpm3_q;
      oor4_q <= oor3_q;
      d_th_q <= tach_pkg::to_ascii(acc4_d[tach_pkg::RpmW + 12 +: 4]);
      d_hu_q <= tach_pkg::to_ascii(acc4_d[tach_pkg::RpmW + 8 +: 4]);
      d_te_q <= tach_pkg::to_ascii(acc4_d[tach_pkg::RpmW + 4 +: 4]);
      d_on_q <= tach_pkg::to_ascii(acc4_d[tach_pkg::RpmW +: 4]);
    end
  end

  assign out_valid_o       = v4_q;
  assign busy_res_o        = ctl4_q.busy;
  assign done_res_o        = ctl4_q.done;
  assign out_of_range_o    = oor4_q;
  assign rpm_o             = rpm4_q;
  assign digit_thousands_o = d_th_q;
  assign digit_hundreds_o  = d_hu_q;
  assign digit_tens_o      = d_te_q;
  assign digit_ones_o      = d_on_q;

endmodule

@@ sv/gated_pulse_tachometer.sv @@
// Gated pulse tachometer top level: configuration registers, front end,
// queue and back end. Depends on tach_pkg, tach_front, tach_queue, tach_back.
//
// Usage: each input word is one tick carrying start_req and the sampled pulse
// level. A start while idle opens a window of gate_ticks ticks (0 acts as 1);
// falling pulse edges inside it are counted. Every input word yields exactly
// one result word: busy, done on the closing tick, and the held rpm, range flag
// and four ASCII digits from the last closed window.
// Configuration: write gate_ticks, max_count, scale by index while idle.
// Flow: a taken input word is written into the 4-entry queue, then passes the
// 4-stage back end; one word per cycle is sustained while out_stall_i is low.
// Output stall: the back end holds its stages, the queue fills, and after it
// is full in_stall_o rises until the receiver takes words again.
// Reset: registers return to 1000000, 166, 60; the window closes and the held
// result clears, so result words read 0 and "0000" until a window closes.
`include "gated_pulse_tachometer_assert.svh"

module gated_pulse_tachometer #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tach_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tach_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            start_req_i,
  input  logic                            pulse_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic                            out_of_range_o,
  output logic [tach_pkg::RpmW-1:0]       rpm_o,
  output logic [tach_pkg::DigitW-1:0]     digit_thousands_o,
  output logic [tach_pkg::DigitW-1:0]     digit_hundreds_o,
  output logic [tach_pkg::DigitW-1:0]     digit_tens_o,
  output logic [tach_pkg::DigitW-1:0]     digit_ones_o
);

  localparam int RecW = COUNT_WIDTH + $bits(tach_pkg::tach_ctl_t);

  logic [tach_pkg::GateW-1:0]   gate_q;
  logic [tach_pkg::MaxCntW-1:0] maxc_q;
  logic [tach_pkg::ScaleW-1:0]  scale_q;

  logic                   accept;
  logic                   q_full, q_valid, q_pop;
  tach_pkg::tach_ctl_t    f_ctl, b_ctl;
  logic [COUNT_WIDTH-1:0] f_count, b_count;
  logic [RecW-1:0]        q_rdata;
  logic                   digits_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q  <= tach_pkg::GateReset;
      maxc_q  <= tach_pkg::MaxCntReset;
      scale_q <= tach_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tach_pkg::CfgGateTicks: gate_q  <= cfg_wdata_i[tach_pkg::GateW-1:0];
        tach_pkg::CfgMaxCount:  maxc_q  <= cfg_wdata_i[tach_pkg::MaxCntW-1:0];
        tach_pkg::CfgScale:     scale_q <= cfg_wdata_i[tach_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  tach_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .start_req_i  (start_req_i),
    .pulse_i      (pulse_i),
    .gate_ticks_i (gate_q),
    .ctl_o        (f_ctl),
    .count_o      (f_count)
  );

  tach_queue #(
    .WIDTH(RecW),
    .DEPTH(tach_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i ({f_ctl, f_count}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign b_ctl   = q_rdata[RecW-1:COUNT_WIDTH];
  assign b_count = q_rdata[COUNT_WIDTH-1:0];

  tach_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_pop_o           (q_pop),
    .ctl_i             (b_ctl),
    .count_i           (b_count),
    .max_count_i       (maxc_q),
    .scale_i           (scale_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .busy_res_o        (busy_res_o),
    .done_res_o        (done_res_o),
    .out_of_range_o    (out_of_range_o),
    .rpm_o             (rpm_o),
    .digit_thousands_o (digit_thousands_o),
    .digit_hundreds_o  (digit_hundreds_o),
    .digit_tens_o      (digit_tens_o),
    .digit_ones_o      (digit_ones_o)
  );

  assign digits_zero = (digit_thousands_o == tach_pkg::AsciiZero) &&
                       (digit_hundreds_o == tach_pkg::AsciiZero) &&
                       (digit_tens_o == tach_pkg::AsciiZero) &&
                       (digit_ones_o == tach_pkg::AsciiZero);

  `TACH_ASSERT_IMP(a_oor_zero_rpm, out_valid_o && out_of_range_o, rpm_o == '0)
  `TACH_ASSERT_IMP(a_done_closes, out_valid_o && done_res_o, !busy_res_o)
  `TACH_ASSERT_IMP(a_zero_digits, out_valid_o && (rpm_o == '0), digits_zero)
  `TACH_ASSERT_NXT(a_pop_needs_entry, q_pop, !$past(q_pop) || q_valid || !q_pop)

endmodule
